### sv/fwf_pkg.sv
// ----------------------------------------------------------------------------
// fwf_pkg
// Shared constants, register indexes and the stage control type for the
// window filter with edge copy.
// ----------------------------------------------------------------------------
package fwf_pkg;

   localparam int MAX_TAPS_DEF    = 7;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int NUM_COEFS       = 7;
   localparam int COEF_W          = 18;
   localparam int COEF_FRAC       = 16;
   localparam int NUM_TAPS_W      = 3;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 18;
   localparam int COEF_UNITY_IDX  = 3;

   localparam logic [NUM_TAPS_W-1:0]    NUM_TAPS_RST = 3'd7;
   localparam logic signed [COEF_W-1:0] COEF_UNITY   = 18'sd65536;
   localparam logic signed [COEF_W-1:0] COEF_ZERO    = 18'sd0;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_TAPS = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_0   = 4'd1;

   // control carried along with each word in the pipeline
   typedef struct packed {
      logic valid;
      logic filt;
      logic last;
   } job_type;

endpackage

### sv/fwf_csr.sv
// ----------------------------------------------------------------------------
// fwf_csr
// Configuration registers: window length and the tap weights.
// ----------------------------------------------------------------------------
module fwf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [fwf_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [fwf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [fwf_pkg::NUM_TAPS_W-1:0]       num_taps,
   output logic signed [fwf_pkg::COEF_W-1:0]    coef [fwf_pkg::NUM_COEFS]
);
   import fwf_pkg::*;

   logic [NUM_TAPS_W-1:0]    num_taps_ff, num_taps_in;
   logic signed [COEF_W-1:0] coef_ff [NUM_COEFS];
   logic signed [COEF_W-1:0] coef_in [NUM_COEFS];

   always_comb begin
      num_taps_in = num_taps_ff;
      for (int k = 0; k < NUM_COEFS; k++) begin
         coef_in[k] = coef_ff[k];
      end
      if (csr_we) begin
         if (csr_addr == CSR_NUM_TAPS) begin
            num_taps_in = csr_wdata[NUM_TAPS_W-1:0];
         end
         for (int k = 0; k < NUM_COEFS; k++) begin
            if (csr_addr == CSR_COEF_0 + CSR_ADDR_W'(k)) begin
               coef_in[k] = $signed(csr_wdata[COEF_W-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff <= NUM_TAPS_RST;
         for (int k = 0; k < NUM_COEFS; k++) begin
            coef_ff[k] <= (k == COEF_UNITY_IDX) ? COEF_UNITY : COEF_ZERO;
         end
      end else begin
         num_taps_ff <= num_taps_in;
         for (int k = 0; k < NUM_COEFS; k++) begin
            coef_ff[k] <= coef_in[k];
         end
      end
   end

   assign num_taps = num_taps_ff;
   always_comb begin
      for (int k = 0; k < NUM_COEFS; k++) begin
         coef[k] = coef_ff[k];
      end
   end

endmodule

### sv/fwf_front.sv
// ----------------------------------------------------------------------------
// fwf_front
// Sample window, sequence counters and end-of-sequence flush sequencer.
// Issues one word per cycle, while s_ready allows, into the product stage with all tap products.
// ----------------------------------------------------------------------------
module fwf_front #(
   parameter int MAX_TAPS    = fwf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fwf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [SAMPLE_BITS-1:0]              req_sample,
   input  logic                                       req_end,
   input  logic [fwf_pkg::NUM_TAPS_W-1:0]             num_taps,
   input  logic signed [fwf_pkg::COEF_W-1:0]          coef [fwf_pkg::NUM_COEFS],
   input  logic                                       s_ready,
   output fwf_pkg::job_type                           p_job,
   output logic signed [SAMPLE_BITS-1:0]              p_raw,
   output logic signed [fwf_pkg::COEF_W+SAMPLE_BITS-1:0] p_prod [MAX_TAPS]
);
   import fwf_pkg::*;

   localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = COEF_W + SAMPLE_BITS;

   logic signed [SAMPLE_BITS-1:0] win_ff [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] win_in [MAX_TAPS];
   logic signed [SAMPLE_BITS-1:0] win_new [MAX_TAPS];
   logic [CNT_W-1:0]              seq_ff, seq_in, pend_ff, pend_in, flush_ff, flush_in;
   job_type                       job_ff, job_in;
   logic signed [SAMPLE_BITS-1:0] raw_ff, raw_in;
   logic signed [PROD_W-1:0]      prod_ff [MAX_TAPS];
   logic signed [PROD_W-1:0]      prod_in [MAX_TAPS];

   logic [NUM_TAPS_W-1:0] taps, right, sel;
   logic [CNT_W-1:0]      seq_new, pend_new, idx, fidx;
   logic                  p_take, accept, emit_main;

   assign p_take    = !job_ff.valid || s_ready;
   assign req_ready = (flush_ff == '0) && p_take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // clamp window length to 1..MAX_TAPS
      if (num_taps == '0) begin
         taps = NUM_TAPS_W'(1);
      end else if (num_taps > NUM_TAPS_W'(MAX_TAPS)) begin
         taps = NUM_TAPS_W'(MAX_TAPS);
      end else begin
         taps = num_taps;
      end
      right = taps - NUM_TAPS_W'(1) - (taps >> 1);

      win_new[0] = req_sample;
      for (int i = 1; i < MAX_TAPS; i++) begin
         win_new[i] = win_ff[i-1];
      end

      seq_new   = (seq_ff == CNT_W'(MAX_TAPS)) ? seq_ff : seq_ff + CNT_W'(1);
      pend_new  = pend_ff + CNT_W'(1);
      idx       = pend_new - CNT_W'(1);
      emit_main = NUM_TAPS_W'(pend_new) > right;
      fidx      = flush_ff - CNT_W'(1);

      // tap k weights the sample t-1-k places back from the newest
      for (int k = 0; k < MAX_TAPS; k++) begin
         sel = taps - NUM_TAPS_W'(1) - NUM_TAPS_W'(k);
         if (NUM_TAPS_W'(k) < taps) begin
            prod_in[k] = coef[k] * win_new[sel[IDX_W-1:0]];
         end else begin
            prod_in[k] = '0;
         end
      end

      win_in       = win_ff;
      seq_in       = seq_ff;
      pend_in      = pend_ff;
      flush_in     = flush_ff;
      job_in.valid = 1'b0;
      job_in.filt  = 1'b0;
      job_in.last  = 1'b0;
      raw_in       = win_new[idx[IDX_W-1:0]];

      if (accept) begin
         win_in       = win_new;
         job_in.valid = emit_main || req_end;
         job_in.filt  = emit_main && (NUM_TAPS_W'(idx) == right)
                        && (NUM_TAPS_W'(seq_new) >= taps);
         job_in.last  = req_end && (idx == '0);
         if (req_end) begin
            // first word goes now, the rest are flushed raw from the window
            seq_in   = '0;
            pend_in  = '0;
            flush_in = idx;
         end else begin
            seq_in  = seq_new;
            pend_in = emit_main ? idx : pend_new;
         end
      end else if (flush_ff != '0 && p_take) begin
         job_in.valid = 1'b1;
         job_in.last  = (fidx == '0);
         raw_in       = win_ff[fidx[IDX_W-1:0]];
         flush_in     = fidx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            win_ff[i] <= '0;
         end
         seq_ff   <= '0;
         pend_ff  <= '0;
         flush_ff <= '0;
         job_ff   <= '0;
      end else begin
         win_ff   <= win_in;
         seq_ff   <= seq_in;
         pend_ff  <= pend_in;
         flush_ff <= flush_in;
         if (p_take) begin
            job_ff <= job_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_take) begin
         raw_ff  <= raw_in;
         prod_ff <= prod_in;
      end
   end

   assign p_job = job_ff;
   assign p_raw = raw_ff;
   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         p_prod[k] = prod_ff[k];
      end
   end

endmodule

### sv/fwf_sum.sv
// ----------------------------------------------------------------------------
// fwf_sum
// Adds the tap products into one registered accumulator.
// ----------------------------------------------------------------------------
module fwf_sum #(
   parameter int MAX_TAPS    = fwf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fwf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  fwf_pkg::job_type                              p_job,
   input  logic signed [SAMPLE_BITS-1:0]                 p_raw,
   input  logic signed [fwf_pkg::COEF_W+SAMPLE_BITS-1:0] p_prod [MAX_TAPS],
   output logic                                          s_ready,
   input  logic                                          o_ready,
   output fwf_pkg::job_type                              s_job,
   output logic signed [SAMPLE_BITS-1:0]                 s_raw,
   output logic signed [fwf_pkg::COEF_W+SAMPLE_BITS+$clog2(MAX_TAPS)-1:0] s_acc
);
   import fwf_pkg::*;

   localparam int ACC_W = COEF_W + SAMPLE_BITS + $clog2(MAX_TAPS);

   job_type                       job_ff;
   logic signed [SAMPLE_BITS-1:0] raw_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   assign s_ready = !job_ff.valid || o_ready;

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
         acc_in = acc_in + ACC_W'(p_prod[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff <= '0;
      end else if (s_ready) begin
         job_ff <= p_job;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready) begin
         raw_ff <= p_raw;
         acc_ff <= acc_in;
      end
   end

   assign s_job = job_ff;
   assign s_raw = raw_ff;
   assign s_acc = acc_ff;

endmodule

### sv/fwf_out.sv
// ----------------------------------------------------------------------------
// fwf_out
// Rounds and saturates the accumulator, picks the raw sample at sequence
// edges, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module fwf_out #(
   parameter int MAX_TAPS    = fwf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fwf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fwf_pkg::job_type                      s_job,
   input  logic signed [SAMPLE_BITS-1:0]         s_raw,
   input  logic signed [fwf_pkg::COEF_W+SAMPLE_BITS+$clog2(MAX_TAPS)-1:0] s_acc,
   output logic                                  o_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [SAMPLE_BITS-1:0]                rsp_value,
   output logic                                  rsp_last
);
   import fwf_pkg::*;

   localparam int ACC_W = COEF_W + SAMPLE_BITS + $clog2(MAX_TAPS);
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - ACC_W'(1);

   logic                    valid_ff, valid_in, last_ff, last_in;
   logic [SAMPLE_BITS-1:0]  value_ff, value_in;
   logic signed [ACC_W-1:0] rounded, sat;

   assign o_ready = !valid_ff || rsp_ready;

   always_comb begin
      // round half up, then clamp to the sample range
      rounded = (s_acc + HALF_LSB) >>> COEF_FRAC;
      if (rounded > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (rounded < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = rounded;
      end
      valid_in = s_job.valid;
      last_in  = s_job.last;
      value_in = s_job.filt ? sat[SAMPLE_BITS-1:0] : s_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (o_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready) begin
         last_ff  <= last_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule

### sv/fir_window_filter_edge_copy.sv
// A result word passes the front, sum and output registers on its way to rsp.
// Throughput: one sample per cycle unless a flush or a stalled rsp holds req_tready low;
// the window and counters update in the accept cycle. A word with req_tlast flushes
// pending results one per unstalled cycle, up to the right-hand reach of the window.
// Reset (synchronous) empties the pipeline, clears window and counters, and loads
// num_taps = 7 with the center weight at unity.
// ----------------------------------------------------------------------------
// fir_window_filter_edge_copy
// Streaming window filter with raw pass-through at sequence edges.
// ----------------------------------------------------------------------------
module fir_window_filter_edge_copy #(
   parameter int MAX_TAPS    = fwf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fwf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,  // sample
   input  logic                                 req_tlast,  // end_of_seq
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,  // out_value
   output logic                                 rsp_tlast,  // out_last
   input  logic                                 csr_we,
   input  logic [fwf_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [fwf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import fwf_pkg::*;

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PROD_W = COEF_W + SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);

   logic [NUM_TAPS_W-1:0]         num_taps;
   logic signed [COEF_W-1:0]      coef [NUM_COEFS];
   job_type                       p_job, s_job;
   logic signed [SAMPLE_BITS-1:0] p_raw, s_raw;
   logic signed [PROD_W-1:0]      p_prod [MAX_TAPS];
   logic signed [ACC_W-1:0]       s_acc;
   logic                          s_ready, o_ready;
   logic [SAMPLE_BITS-1:0]        rsp_value;

   fwf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .num_taps  (num_taps),
      .coef      (coef)
   );

   fwf_front #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .req_end    (req_tlast),
      .num_taps   (num_taps),
      .coef       (coef),
      .s_ready    (s_ready),
      .p_job      (p_job),
      .p_raw      (p_raw),
      .p_prod     (p_prod)
   );

   fwf_sum #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_sum (
      .clock   (clock),
      .reset   (reset),
      .p_job   (p_job),
      .p_raw   (p_raw),
      .p_prod  (p_prod),
      .s_ready (s_ready),
      .o_ready (o_ready),
      .s_job   (s_job),
      .s_raw   (s_raw),
      .s_acc   (s_acc)
   );

   fwf_out #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .s_job     (s_job),
      .s_raw     (s_raw),
      .s_acc     (s_acc),
      .o_ready   (o_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'(rsp_value);

endmodule

### sv/fwf_checker.sv
// ----------------------------------------------------------------------------
// fwf_checker
// Port-level checks on reset recovery and the result channel.
// ----------------------------------------------------------------------------
module fwf_checker #(
   parameter int DATA_W = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // pipeline is empty right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      disable iff (reset) $past(reset) |-> !rsp_tvalid)
      else $error("result word present right after reset");

   // no flush pending right after reset, so input is open
   a_ready_after_reset: assert property (@(posedge clock)
      disable iff (reset) $past(reset) |-> req_tready)
      else $error("input not ready right after reset");

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock)
      disable iff (reset) rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

endmodule

bind fir_window_filter_edge_copy fwf_checker #(
   .DATA_W(((SAMPLE_BITS + 7) / 8) * 8)
) u_fwf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
